// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions with a clock and an active low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on a given clock, disabled while reset is low.
`define PRE_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on clk_i and rst_ni.
`define PRE_ASSERT(lbl, prop, msg) \
  `PRE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/pre_pkg.sv -----
// ----------------------------------------------------------------------------
// pre_pkg
// Types and constants of the packet rate estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pre_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned RateW   = 32;
  localparam int unsigned TpsW    = 32;
  localparam int unsigned ProdW   = LenW + TpsW;     // length times ticks per second
  localparam int unsigned NumW    = ProdW + 3;       // times 8 bits per byte
  localparam int unsigned DivW    = 32;              // quotient, divisor and remainder
  localparam int unsigned DivSteps = DivW;
  localparam int unsigned DivCntW = $clog2(DivSteps);

  localparam logic [TpsW-1:0] TpsReset = TpsW'(1000000000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PKT_GO,
    ST_PKT_WAIT,
    ST_BIT_GO,
    ST_BIT_WAIT,
    ST_WRITE
  } pre_state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num_hi;
    logic [DivW-1:0] num_lo;
    logic [DivW-1:0] divisor;
  } pre_div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } pre_div_rsp_t;

endpackage

// ----- hw/rtl/pre_if.sv -----
// ----------------------------------------------------------------------------
// pre_if
// Valid/ready channels of the packet rate estimator: packets, rates, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pre_in_if import pre_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] arrival_time;
  logic [LenW-1:0]  packet_length;

  modport source (output valid, output arrival_time, output packet_length, input ready);
  modport sink   (input valid, input arrival_time, input packet_length, output ready);
endinterface

interface pre_out_if import pre_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RateW-1:0] packet_rate;
  logic [RateW-1:0] bit_rate;
  logic             zero_gap;

  modport source (output valid, output packet_rate, output bit_rate, output zero_gap,
                  input ready);
  modport sink   (input valid, input packet_rate, input bit_rate, input zero_gap,
                  output ready);
endinterface

interface pre_cfg_if import pre_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [TpsW-1:0] ticks_per_second;

  modport source (output valid, output ticks_per_second, input ready);
  modport sink   (input valid, input ticks_per_second, output ready);
endinterface

// ----- hw/rtl/packet_rate_estimator.sv -----
// Sequence: a packet beat starts a divide for the packet sample, then one for
//   the bit sample, then the write; a saturating divide skips its steps.
// Flow: one packet at a time on the single shared divider; a new packet waits
//   for the write, which waits for a free output. A zero gap skips both divides.
// Reset: rst_ni clears the averages and the last timestamp, loads ticks per
//   second with 1000000000; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_rate_estimator
// Half-weight moving averages of packet and bit rate from arrival timestamps.
// ----------------------------------------------------------------------------

`include "assert_macros.svh"

module packet_rate_estimator import pre_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pre_cfg_if.sink    cfg_i,
  pre_in_if.sink     pkt_i,
  pre_out_if.source  rate_o
);

  pre_state_e       state_q, state_d;

  // --------------------------------------------------------------------------
  // Configuration: ticks per second, written only while the sequencer is idle.
  // --------------------------------------------------------------------------
  logic [TpsW-1:0] tps_q;

  assign cfg_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TpsReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      tps_q <= cfg_i.ticks_per_second;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  logic             pkt_beat;
  logic             rate_beat;
  logic             out_free;
  logic             div_start;
  logic             write_en;
  logic             div_wait;

  logic [TimeW-1:0] last_q;       // previous arrival timestamp
  logic [TimeW-1:0] gap_q;        // divisor of both samples
  logic             zero_q;       // zero gap seen on the current packet
  logic [ProdW-1:0] prod_q;       // packet length times ticks per second
  logic [RateW-1:0] pkt_smp_q;    // packets per second sample
  logic [RateW-1:0] pkt_avg_q;
  logic [RateW-1:0] bit_avg_q;
  logic             out_valid_q;
  logic             out_zero_q;

  logic [TimeW-1:0] gap;
  logic [NumW-1:0]  bit_num;
  logic [RateW:0]   pkt_sum;
  logic [RateW:0]   bit_sum;

  pre_div_req_t     div_req;
  pre_div_rsp_t     div_rsp;

  assign pkt_beat  = pkt_i.valid & pkt_i.ready;
  assign rate_beat = rate_o.valid & rate_o.ready;
  // the output register may take a new result once the old one is gone
  assign out_free  = !out_valid_q || rate_o.ready;
  assign div_wait  = (state_q == ST_PKT_WAIT) || (state_q == ST_BIT_WAIT);

  // modulo 2^32 gap from the previous timestamp
  assign gap = pkt_i.arrival_time - last_q;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pkt_beat) begin
          state_d = (gap == '0) ? ST_WRITE : ST_PKT_GO;
        end
      end
      ST_PKT_GO:   state_d = ST_PKT_WAIT;
      ST_PKT_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_BIT_GO;
        end
      end
      ST_BIT_GO:   state_d = ST_BIT_WAIT;
      ST_BIT_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    pkt_i.ready = 1'b0;
    div_start   = 1'b0;
    write_en    = 1'b0;
    unique case (state_q)
      ST_IDLE:                 pkt_i.ready = 1'b1;
      ST_PKT_GO, ST_BIT_GO:    div_start   = 1'b1;
      ST_PKT_WAIT, ST_BIT_WAIT: ;
      ST_WRITE:                write_en    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider requests: packets = tps / gap, bits = len * 8 * tps / gap.
  // The divider saturates when the upper numerator word is not below the gap.
  // --------------------------------------------------------------------------
  assign bit_num = {prod_q, 3'b000};

  always_comb begin
    div_req.start   = div_start;
    div_req.divisor = gap_q;
    if (state_q == ST_BIT_GO) begin
      div_req.num_hi = DivW'(bit_num[NumW-1:DivW]);
      div_req.num_lo = bit_num[DivW-1:0];
    end else begin
      div_req.num_hi = '0;
      div_req.num_lo = tps_q;
    end
  end

  pre_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Datapath: capture the packet, keep the packet sample, update the averages
  // --------------------------------------------------------------------------
  assign pkt_sum = {1'b0, pkt_avg_q} + {1'b0, pkt_smp_q};
  assign bit_sum = {1'b0, bit_avg_q} + {1'b0, div_rsp.quot};

  always_ff @(posedge clk_i) begin
    if (pkt_beat) begin
      gap_q  <= gap;
      zero_q <= (gap == '0);
      prod_q <= ProdW'(pkt_i.packet_length) * ProdW'(tps_q);
    end
    if (state_q == ST_PKT_WAIT && div_rsp.done) begin
      pkt_smp_q <= div_rsp.quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      pkt_avg_q   <= '0;
      bit_avg_q   <= '0;
      out_valid_q <= 1'b0;
      out_zero_q  <= 1'b0;
    end else begin
      if (pkt_beat) begin
        last_q <= pkt_i.arrival_time;
      end
      // the quotient register still holds the bit sample while in ST_WRITE
      if (write_en) begin
        out_zero_q <= zero_q;
        if (!zero_q) begin
          pkt_avg_q <= pkt_sum[RateW:1];
          bit_avg_q <= bit_sum[RateW:1];
        end
      end
      if (write_en) begin
        out_valid_q <= 1'b1;
      end else if (rate_beat) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // the averages are the result; they only move when the output is free
  assign rate_o.valid       = out_valid_q;
  assign rate_o.packet_rate = pkt_avg_q;
  assign rate_o.bit_rate    = bit_avg_q;
  assign rate_o.zero_gap    = out_zero_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `PRE_ASSERT(a_done_when_waiting, div_rsp.done |-> div_wait, "divider done outside a wait")
  `PRE_ASSERT(a_result_from_write, $rose(out_valid_q) |-> $past(write_en), "result without write")
  `PRE_ASSERT(a_avg_hold, !write_en |=> $stable(pkt_avg_q) && $stable(bit_avg_q), "averages moved")
  `PRE_ASSERT(a_no_overwrite, (out_valid_q && !rate_o.ready) |-> !write_en, "result overwritten")

endmodule

// ----- hw/rtl/pre_div.sv -----
// ----------------------------------------------------------------------------
// pre_div
// Restoring divider, one quotient bit a cycle, saturating 64 by 32 bit divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pre_div import pre_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  pre_div_req_t req_i,
  output pre_div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DivW-1:0]    div_q, div_d;
  logic [DivW:0]      trial;
  logic [DivW:0]      diff;
  logic               fits;

  // shift in the next numerator bit, then compare and subtract
  assign trial = {rem_q, quo_q[DivW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      div_d = req_i.divisor;
      cnt_d = '0;
      if (req_i.num_hi >= req_i.divisor) begin
        // quotient does not fit: saturate at once
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = req_i.num_hi;
        quo_d  = req_i.num_lo;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = fits ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_d = {quo_q[DivW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ----- tb/packet_rate_estimator_tb.sv -----
// ----------------------------------------------------------------------------
// packet_rate_estimator_tb
// Self-checking bench for the packet rate estimator. A directed table walks
// reset behavior, timestamp wrap, zero gaps, saturation and the extremes of
// ticks per second. Random traffic follows in several register settings.
// Every rate beat is compared field by field with the rate model or a row literal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_rate_estimator_tb;
  import pre_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned IdlePct       = 29;    // percent of cycles a side idles
  localparam int unsigned HoldOffCycles = 600;   // one long stall of the rate sink
  localparam int unsigned HoldOffAfter  = 60;    // rate beats seen before that stall
  localparam int unsigned WatchdogLimit = 4000;  // cycles without any beat
  localparam int unsigned DrainCycles   = 100;   // quiet time after the last owed beat
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned PhaseItems    = 100;
  localparam int unsigned NumPhases     = 4;
  localparam int unsigned SteadyItems   = 60;
  localparam int unsigned NumDirected   = 21;
  localparam int unsigned BitsPerByte   = 8;
  localparam logic [RateW-1:0] RateMax  = '1;

  typedef enum logic {
    ROW_PKT,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    logic [RateW-1:0] packet_rate;
    logic [RateW-1:0] bit_rate;
    logic             zero_gap;
  } rate_beat_t;

  // One directed step: a packet beat or a ticks per second write. Rows marked
  // literal carry the rate beat that must come back; the rest use the model.
  typedef struct {
    row_kind_e        kind;
    logic [TimeW-1:0] value;
    logic [LenW-1:0]  length;
    bit               literal;
    logic [RateW-1:0] lit_pkt;
    logic [RateW-1:0] lit_bit;
    logic             lit_zero;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  pre_cfg_if cfg_ch ();
  pre_in_if  pkt_ch ();
  pre_out_if rate_ch ();

  packet_rate_estimator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .pkt_i  (pkt_ch),
    .rate_o (rate_ch)
  );

  // Rate model state: register copy, last timestamp, both running averages.
  logic [TpsW-1:0]  tps_model;
  logic [TimeW-1:0] last_arrival_model;
  logic [RateW-1:0] pkt_avg_model;
  logic [RateW-1:0] bit_avg_model;

  rate_beat_t  rate_q[$];          // rate beats still owed by the block
  int unsigned mismatch_count = 0;
  int unsigned beats_seen     = 0;
  int unsigned stuck_cycles   = 0;
  bit          steady_flow    = 1'b0;  // both sides stop idling while set

  stim_row_t directed_rows [NumDirected] = '{
    // first packet at time zero: zero gap against the cleared timestamp
    '{ROW_PKT, 32'h0000_0000, 16'h0000, 1'b1, 32'd0,         32'd0,          1'b1},
    // gap of one tick, largest length: bit sample saturates
    '{ROW_PKT, 32'h0000_0001, 16'hFFFF, 1'b1, 32'd500000000, 32'd2147483647, 1'b0},
    // repeated stamp: hold both averages
    '{ROW_PKT, 32'h0000_0001, 16'h0064, 1'b1, 32'd500000000, 32'd2147483647, 1'b1},
    // stamp wraps backward: gap is all ones, both samples vanish
    '{ROW_PKT, 32'h0000_0000, 16'h0000, 1'b1, 32'd250000000, 32'd1073741823, 1'b0},
    '{ROW_PKT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h0000_0000, 16'h0001, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h0000_03E8, 16'd1500, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h0000_2328, 16'd64,   1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'hAAAA_AAAA, 16'h5555, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h5555_5555, 16'hAAAA, 1'b0, '0, '0, 1'b0},
    // largest tick rate: packet sample reaches the top, bit sample saturates
    '{ROW_CFG, 32'hFFFF_FFFF, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h5555_5556, 16'hFFFF, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h5555_5556, 16'h0000, 1'b0, '0, '0, 1'b0},
    // smallest nonzero tick rate
    '{ROW_CFG, 32'h0000_0001, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h5555_5557, 16'hFFFF, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h5555_6000, 16'd40,   1'b0, '0, '0, 1'b0},
    // zero tick rate: samples are zero, averages halve toward zero
    '{ROW_CFG, 32'h0000_0000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h5556_0000, 16'd1500, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h5556_0000, 16'd1500, 1'b0, '0, '0, 1'b0},
    // back to the reset tick rate
    '{ROW_CFG, 32'd1000000000, 16'h0000, 1'b0, '0, '0, 1'b0},
    '{ROW_PKT, 32'h5556_0010, 16'h8000, 1'b0, '0, '0, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Rate model
  // --------------------------------------------------------------------------

  // Clamp a 64-bit quotient to the 32-bit rate range.
  function automatic logic [RateW-1:0] saturate_rate(input logic [63:0] v);
    return (v > 64'(RateMax)) ? RateMax : v[RateW-1:0];
  endfunction

  // Half-weight average; the 33-bit sum always shifts back into 32 bits.
  function automatic logic [RateW-1:0] blend_half(input logic [RateW-1:0] avg,
                                                  input logic [RateW-1:0] sample);
    logic [RateW:0] sum;
    sum = {1'b0, avg} + {1'b0, sample};
    return sum[RateW:1];
  endfunction

  // Advance the model by one packet and return the rate beat it implies.
  function automatic rate_beat_t update_rates(input logic [TimeW-1:0] now,
                                              input logic [LenW-1:0]  len);
    logic [TimeW-1:0] gap;
    logic [63:0]      tps_wide;
    rate_beat_t       beat;
    gap      = now - last_arrival_model;   // wraps modulo 2^32
    tps_wide = 64'(tps_model);
    beat.zero_gap = (gap == '0);
    if (!beat.zero_gap) begin
      pkt_avg_model = blend_half(pkt_avg_model, saturate_rate(tps_wide / 64'(gap)));
      bit_avg_model = blend_half(bit_avg_model,
          saturate_rate((64'(len) * 64'(BitsPerByte) * tps_wide) / 64'(gap)));
    end
    last_arrival_model = now;
    beat.packet_rate = pkt_avg_model;
    beat.bit_rate    = bit_avg_model;
    return beat;
  endfunction

  // --------------------------------------------------------------------------
  // Packet and register drivers
  // --------------------------------------------------------------------------

  // Idle at random, offer one packet beat, hold it until taken, then record
  // the rate beat it owes. Use the literal in place of the model's beat when
  // the row carries one; the model still advances.
  task automatic offer_packet(input logic [TimeW-1:0] now, input logic [LenW-1:0] len,
                              input bit use_literal, input rate_beat_t literal);
    rate_beat_t beat;
    if (!steady_flow) begin
      while ($urandom_range(99) < IdlePct) begin
        pkt_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    pkt_ch.valid         <= 1'b1;
    pkt_ch.arrival_time  <= now;
    pkt_ch.packet_length <= len;
    do @(posedge clk_i); while (!pkt_ch.ready);
    beat = update_rates(now, len);
    rate_q.push_back(use_literal ? literal : beat);
  endtask

  // Drain every owed rate beat, then write ticks per second. The block stalls
  // the write through ready while it finishes any work in flight.
  task automatic write_tick_rate(input logic [TpsW-1:0] tps);
    pkt_ch.valid <= 1'b0;
    while (rate_q.size() != 0) @(posedge clk_i);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.ticks_per_second <= tps;
    do @(posedge clk_i); while (!cfg_ch.ready);
    tps_model = tps;
    cfg_ch.valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Rate sink: random backpressure, a quiet stretch while steady_flow is set,
  // and one long hold-off so the block fills up and stalls its packet input.
  // --------------------------------------------------------------------------
  initial begin
    bit held_off;
    held_off = 1'b0;
    rate_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_off && beats_seen >= HoldOffAfter) begin
        held_off = 1'b1;
        rate_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        rate_ch.ready <= steady_flow || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Rate checker: compare each rate beat with the oldest owed beat.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rate_beat_t got;
    rate_beat_t want;
    if (rst_ni && rate_ch.valid && rate_ch.ready) begin
      got = '{packet_rate: rate_ch.packet_rate, bit_rate: rate_ch.bit_rate,
              zero_gap: rate_ch.zero_gap};
      beats_seen++;
      if (rate_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: unexpected rate beat pkt=%0d bit=%0d zero=%0b",
                   $time, got.packet_rate, got.bit_rate, got.zero_gap);
      end else begin
        want = rate_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: rate beat %0d: expected pkt=%0d bit=%0d zero=%0b, got pkt=%0d bit=%0d zero=%0b",
                     $time, beats_seen, want.packet_rate, want.bit_rate, want.zero_gap,
                     got.packet_rate, got.bit_rate, got.zero_gap);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no beat moves on any channel for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((pkt_ch.valid && pkt_ch.ready) || (rate_ch.valid && rate_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WatchdogLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [TimeW-1:0] next_time;
    logic [LenW-1:0]  next_len;
    logic [TpsW-1:0]  phase_tps [NumPhases];
    rate_beat_t       literal;
    int unsigned      pick;

    // Hold reset and park every input at a known value.
    rst_ni                  <= 1'b0;
    pkt_ch.valid            <= 1'b0;
    pkt_ch.arrival_time     <= '0;
    pkt_ch.packet_length    <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.ticks_per_second <= '0;

    tps_model          = TpsReset;
    last_arrival_model = '0;
    pkt_avg_model      = '0;
    bit_avg_model      = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_tick_rate(directed_rows[i].value);
      end else begin
        literal = '{packet_rate: directed_rows[i].lit_pkt, bit_rate: directed_rows[i].lit_bit,
                    zero_gap: directed_rows[i].lit_zero};
        offer_packet(directed_rows[i].value, directed_rows[i].length,
                     directed_rows[i].literal, literal);
      end
    end

    // Random traffic, one register setting per phase, extremes among them.
    phase_tps[0] = $urandom;
    phase_tps[1] = '1;
    phase_tps[2] = TpsW'(1);
    phase_tps[3] = TpsW'(125000000);
    next_time = last_arrival_model;
    literal   = '0;
    for (int p = 0; p < NumPhases; p++) begin
      write_tick_rate(phase_tps[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        // Run the opening of one phase with both sides flat out.
        steady_flow = (p == 2) && (n < SteadyItems);

        // Mix gap sizes: repeats, short bursts, typical spacing, long silences.
        pick = $urandom_range(99);
        if (pick < 8)       next_time = next_time;
        else if (pick < 40) next_time = next_time + $urandom_range(64, 1);
        else if (pick < 70) next_time = next_time + $urandom_range(32'h0001_0000, 65);
        else if (pick < 90) next_time = next_time + $urandom_range(32'h0100_0000, 32'h0001_0000);
        else                next_time = $urandom;

        // Lengths: empty, largest, typical frames, anything.
        pick = $urandom_range(99);
        if (pick < 10)      next_len = '0;
        else if (pick < 20) next_len = '1;
        else if (pick < 60) next_len = LenW'($urandom_range(1500, 40));
        else                next_len = LenW'($urandom_range(65535, 0));

        offer_packet(next_time, next_len, 1'b0, literal);
      end
    end
    steady_flow = 1'b0;

    // Drop valid, collect every owed beat, then watch for strays.
    pkt_ch.valid <= 1'b0;
    while (rate_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    mismatch_count += rate_q.size();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pre_pkg.sv
hw/rtl/pre_if.sv
hw/rtl/pre_div.sv
hw/rtl/packet_rate_estimator.sv
tb/packet_rate_estimator_tb.sv
